FILE: hw/rtl/lfp_pkg.sv
// shared types and constants of the laser point frame player
`default_nettype none

package lfp_pkg;

    // command codes of an input word
    localparam logic [1:0] CMD_WRITE  = 2'd0;
    localparam logic [1:0] CMD_COMMIT = 2'd1;
    localparam logic [1:0] CMD_TICK   = 2'd2;

    // configuration register indexes
    localparam logic [7:0] CFG_TICK_DIVIDER = 8'd0;
    localparam logic [7:0] CFG_OUTPUT_GAIN  = 8'd1;

    localparam logic [7:0]  TICK_DIVIDER_RESET = 8'd1;
    localparam logic [15:0] OUTPUT_GAIN_RESET  = 16'd32768;

    // one stored point
    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic               blank;
        logic               last;
    } point_t;

endpackage

`default_nettype wire

FILE: hw/rtl/laser_point_frame_player_unit.sv
// top level of the double-buffered laser point frame player
// a tick word's result passes the product register, then rounding and saturation
//   into the output register
// throughput: one word per cycle unless stalled; the play position's point is
//   prefetched from point memory every cycle, so back-to-back ticks never wait
// reset: asynchronous, active low; counts, bank select, position, hold counter,
//   pending flag and pipeline valids clear; the point memory is not cleared
`default_nettype none

module laser_point_frame_player_unit
    import lfp_pkg::*;
#(
    parameter int POINTS_PER_BANK = 4096,
    parameter int BANKS           = 2
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    // command channel
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [1:0]         cmd,
    input  wire logic [11:0]        point_index,
    input  wire logic signed [15:0] in_x,
    input  wire logic signed [15:0] in_y,
    input  wire logic signed [15:0] in_z,
    input  wire logic               in_blank,
    input  wire logic               in_last,
    input  wire logic [12:0]        frame_count,
    // sample channel
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [15:0]      x_out,
    output logic signed [15:0]      y_out,
    output logic signed [15:0]      z_out,
    output logic                    laser_on,
    output logic                    frame_swapped,
    // configuration channel
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [7:0]         cfg_index,
    input  wire logic [15:0]        cfg_data
);

    localparam int PW    = $clog2(POINTS_PER_BANK);
    localparam int CW    = $clog2(POINTS_PER_BANK + 1);
    localparam int BW    = $clog2(BANKS);
    localparam int DEPTH = BANKS * POINTS_PER_BANK;
    localparam int AW    = $clog2(DEPTH);

    localparam logic [CW-1:0] COUNT_MAX = CW'(POINTS_PER_BANK);
    localparam logic [BW-1:0] BANK_LAST = BW'(BANKS - 1);

    // configuration registers
    logic [7:0]  tick_divider_reg;
    logic [15:0] output_gain_reg;

    // player state
    logic [CW-1:0] bank_count_reg [BANKS];
    logic [BW-1:0] display_bank_reg, display_bank_next;
    logic [PW-1:0] play_position_reg, play_position_next;
    logic [7:0]    hold_count_reg, hold_count_next;
    logic          swap_pending_reg, swap_pending_next;

    // pipeline: stage 1 holds products, stage 2 is the output register
    logic               s1_valid_reg;
    logic signed [32:0] prod_x_reg, prod_y_reg, prod_z_reg;
    logic               s1_laser_reg, s1_swapped_reg;
    logic               out_valid_reg;
    logic signed [15:0] x_out_reg, y_out_reg, z_out_reg;
    logic               laser_on_reg, frame_swapped_reg;

    logic s2_ready, s1_ready, accept;
    logic is_write, is_commit, is_tick;

    logic [BW-1:0] hidden_bank;
    logic [CW-1:0] cur_count, commit_count;
    logic          empty;
    logic          swapped;
    point_t        cur_point, shown_point, new_point;
    logic          wr_en;
    logic [AW-1:0] wr_addr, rd_addr;

    // bank and slot to flat memory address
    function automatic logic [AW-1:0] flat_addr(input logic [BW-1:0] bank,
                                                input logic [PW-1:0] pos);
        flat_addr = AW'(32'(bank) * POINTS_PER_BANK + 32'(pos));
    endfunction

    // q15 rounding (halves up) and 16 bit saturation of a product
    function automatic logic signed [15:0] round_sat(input logic signed [32:0] p);
        logic signed [33:0] s;
        logic signed [18:0] q;
        s = 34'(p) + 34'sd16384;
        q = s[33:15];
        if (q > 19'sd32767)
            round_sat = 16'sh7fff;
        else if (q < -19'sd32768)
            round_sat = -16'sh8000;
        else
            round_sat = q[15:0];
    endfunction

    // handshake: stall only while both pipeline stages are held
    assign s2_ready  = !out_valid_reg || !out_stall;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign in_stall  = !s1_ready;
    assign accept    = in_valid && s1_ready;
    assign cfg_ready = 1'b1;

    assign is_write  = accept && (cmd == CMD_WRITE);
    assign is_commit = accept && (cmd == CMD_COMMIT);
    assign is_tick   = accept && (cmd == CMD_TICK);

    assign hidden_bank = (display_bank_reg == BANK_LAST) ? '0 : display_bank_reg + 1'b1;

    // commit saturates the count to the bank size
    assign commit_count = (32'(frame_count) > POINTS_PER_BANK) ?
                          COUNT_MAX : CW'(frame_count);

    // write path into the hidden bank; out of range slots are dropped
    assign new_point = '{x: in_x, y: in_y, z: in_z, blank: in_blank, last: in_last};
    assign wr_en     = is_write && (32'(point_index) < POINTS_PER_BANK);
    assign wr_addr   = flat_addr(hidden_bank, PW'(point_index));

    // prefetch the point at the next position; writes only touch the hidden
    // bank, so this read never collides with a write in the same cycle
    assign rd_addr = flat_addr(display_bank_next, play_position_next);

    lfp_point_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (new_point),
        .rd_addr (rd_addr),
        .rd_data (cur_point)
    );

    // commit arms a swap; tick: pick point, step hold and position, swap at 0
    always_comb
    begin
        logic [CW-1:0] pos_inc;
        pos_inc            = CW'(play_position_reg) + 1'b1;
        cur_count          = bank_count_reg[display_bank_reg];
        empty              = (cur_count == '0) || (CW'(play_position_reg) >= cur_count);
        shown_point        = empty ? point_t'{x: '0, y: '0, z: '0, blank: 1'b1, last: 1'b0}
                                   : cur_point;
        display_bank_next  = display_bank_reg;
        play_position_next = play_position_reg;
        hold_count_next    = hold_count_reg;
        swap_pending_next  = swap_pending_reg;
        swapped            = 1'b0;
        if (is_commit)
        begin
            swap_pending_next = 1'b1;
        end
        else if (is_tick)
        begin
            hold_count_next = hold_count_reg + 8'd1;
            if (hold_count_next == tick_divider_reg)
            begin
                hold_count_next = '0;
                if (empty || shown_point.last || (pos_inc >= cur_count))
                    play_position_next = '0;
                else
                    play_position_next = pos_inc[PW-1:0];
            end
            if ((play_position_next == '0) && swap_pending_reg)
            begin
                display_bank_next = hidden_bank;
                swap_pending_next = 1'b0;
                swapped           = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_divider_reg  <= TICK_DIVIDER_RESET;
            output_gain_reg   <= OUTPUT_GAIN_RESET;
            for (int b = 0; b < BANKS; b++)
            begin
                bank_count_reg[b] <= '0;
            end
            display_bank_reg  <= '0;
            play_position_reg <= '0;
            hold_count_reg    <= '0;
            swap_pending_reg  <= 1'b0;
            s1_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_TICK_DIVIDER)
                    tick_divider_reg <= cfg_data[7:0];
                else if (cfg_index == CFG_OUTPUT_GAIN)
                    output_gain_reg <= cfg_data;
            end
            if (is_commit)
            begin
                bank_count_reg[hidden_bank] <= commit_count;
            end
            display_bank_reg  <= display_bank_next;
            play_position_reg <= play_position_next;
            hold_count_reg    <= hold_count_next;
            swap_pending_reg  <= swap_pending_next;
            if (s1_ready)
                s1_valid_reg <= is_tick;
            if (s2_ready)
                out_valid_reg <= s1_valid_reg;
        end
    end

    // payload: products, then rounded samples
    always_ff @(posedge clk)
    begin
        if (is_tick)
        begin
            prod_x_reg     <= shown_point.x * $signed({1'b0, output_gain_reg});
            prod_y_reg     <= shown_point.y * $signed({1'b0, output_gain_reg});
            prod_z_reg     <= shown_point.z * $signed({1'b0, output_gain_reg});
            s1_laser_reg   <= !shown_point.blank;
            s1_swapped_reg <= swapped;
        end
        if (s2_ready && s1_valid_reg)
        begin
            x_out_reg         <= round_sat(prod_x_reg);
            y_out_reg         <= round_sat(prod_y_reg);
            z_out_reg         <= round_sat(prod_z_reg);
            laser_on_reg      <= s1_laser_reg;
            frame_swapped_reg <= s1_swapped_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign x_out         = x_out_reg;
    assign y_out         = y_out_reg;
    assign z_out         = z_out_reg;
    assign laser_on      = laser_on_reg;
    assign frame_swapped = frame_swapped_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/lfp_point_ram.sv
// point store: one write port, one registered read port
`default_nettype none

module lfp_point_ram
    import lfp_pkg::*;
#(
    parameter int DEPTH = 8192,
    parameter int AW    = 13
)
(
    input  wire logic          clk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire point_t        wr_data,
    input  wire logic [AW-1:0] rd_addr,
    output point_t             rd_data
);

    point_t mem [DEPTH];
    point_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/lfp_checker.sv
// port level checks of the laser point frame player and their bind
`default_nettype none

module lfp_checker
    import lfp_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_valid,
    input wire logic               in_stall,
    input wire logic [1:0]         cmd,
    input wire logic               out_valid,
    input wire logic               out_stall,
    input wire logic signed [15:0] x_out,
    input wire logic signed [15:0] y_out,
    input wire logic signed [15:0] z_out,
    input wire logic               laser_on,
    input wire logic               frame_swapped
);

    logic commit_seen_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            commit_seen_reg <= 1'b0;
        else if (in_valid && !in_stall && (cmd == CMD_COMMIT))
            commit_seen_reg <= 1'b1;
    end

    // held result word stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(x_out) && $stable(y_out)
            && $stable(z_out) && $stable(laser_on) && $stable(frame_swapped))
        else $error("result word changed while stalled");

    // with no result waiting the pipeline cannot be full
    a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled with empty output");

    // an accepted tick reaches the output when the sink does not stall
    a_tick_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && (cmd == CMD_TICK)) ##1 !out_stall |=> out_valid)
        else $error("tick result missing");

    // before any commit every bank is empty: blanked zero samples, no swap
    a_empty_before_commit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !commit_seen_reg |-> !laser_on && !frame_swapped
            && (x_out == 16'sd0) && (y_out == 16'sd0) && (z_out == 16'sd0))
        else $error("sample from empty bank not blanked zero");

endmodule

bind laser_point_frame_player_unit lfp_checker u_lfp_checker (.*);

`default_nettype wire

FILE: tb/laser_point_frame_player_unit_tb.sv
// self-checking testbench for the laser point frame player unit
`timescale 1ns / 1ps

module laser_point_frame_player_unit_tb;

    import lfp_pkg::*;

    // geometry of the point memory
    localparam int PPB = 4096;
    localparam int STORE_DEPTH = 2 * PPB;

    // cmd 3 has no name in the package, the block ignores it
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // the two copies of the player state: one runs ahead while words are
    // generated, one follows the words that the block actually takes
    localparam int AHEAD = 0;
    localparam int LIVE  = 1;

    localparam int WORDS_PER_PHASE = 80;
    localparam int NUM_PHASES      = 8;
    localparam int SETTLE_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT  = 4000;

    // one command word as seen on the input ports
    typedef struct packed {
        logic [1:0]         cmd;
        logic [11:0]        slot;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic               blank;
        logic               last;
        logic [12:0]        frame_len;
    } word_t;

    // one output sample word
    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic               laser_on;
        logic               swapped;
    } out_word_t;

    // clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // command channel
    logic               in_valid    = 1'b0;
    logic               in_stall;
    logic [1:0]         cmd         = CMD_WRITE;
    logic [11:0]        point_index = '0;
    logic signed [15:0] in_x        = '0;
    logic signed [15:0] in_y        = '0;
    logic signed [15:0] in_z        = '0;
    logic               in_blank    = 1'b0;
    logic               in_last     = 1'b0;
    logic [12:0]        frame_count = '0;

    // sample channel
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic signed [15:0] x_out;
    logic signed [15:0] y_out;
    logic signed [15:0] z_out;
    logic               laser_on;
    logic               frame_swapped;

    // configuration channel
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [7:0]         cfg_index = '0;
    logic [15:0]        cfg_data  = '0;

    // register values as the block holds them, shared by both state copies
    // since registers only change while the block is idle
    bit [7:0]  tick_div  = TICK_DIVIDER_RESET;
    bit [15:0] coord_gain = OUTPUT_GAIN_RESET;

    // player state, one copy per index AHEAD / LIVE
    point_t    pt_mem [2][STORE_DEPTH];
    int        bank_len [2][2]  = '{default: 0};
    bit        disp_bank [2]    = '{default: 1'b0};
    int        play_pos [2]     = '{default: 0};
    bit [7:0]  hold_cnt [2]     = '{default: 8'd0};
    bit        swap_pending [2] = '{default: 1'b0};

    // slots already written, tracked on the look-ahead copy only
    bit        slot_written [STORE_DEPTH] = '{default: 1'b0};

    // words waiting for the driver and samples waiting for the block
    word_t     command_fifo [$];
    out_word_t sample_fifo [$];
    word_t     bus_word;

    int        words_queued    = 0;
    int        words_accepted  = 0;
    int        words_this_phase = 0;
    int        mismatches      = 0;
    int        idle_cycles     = 0;

    // sender burst shaping
    int        gap_left       = 0;
    int        burst_left     = 0;
    bit        hold_for_drain = 1'b0;

    // receiver stall pattern
    int        stall_mode     = 0;
    int        mode_left      = 0;
    int unsigned stall_cyc    = 0;

    // phase settings, the last one is replaced by random values
    bit [7:0]  div_set  [NUM_PHASES] = '{8'd2, 8'd1, 8'd255, 8'd0, 8'd3, 8'd1, 8'd4, 8'd1};
    bit [15:0] gain_set [NUM_PHASES] = '{16'd16384, 16'd0, 16'd32768, 16'd65535,
                                         16'd24576, 16'd40000, 16'd32767, 16'd1};

    laser_point_frame_player_unit DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .cmd           (cmd),
        .point_index   (point_index),
        .in_x          (in_x),
        .in_y          (in_y),
        .in_z          (in_z),
        .in_blank      (in_blank),
        .in_last       (in_last),
        .frame_count   (frame_count),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .x_out         (x_out),
        .y_out         (y_out),
        .z_out         (z_out),
        .laser_on      (laser_on),
        .frame_swapped (frame_swapped),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // q15 gain with round half up, i.e. floor of (c * gain + 0.5 lsb),
    // then clamp to the 16 bit range
    function automatic logic signed [15:0] scale_coord(input logic signed [15:0] c);
        longint acc;
        acc = longint'(c) * longint'(coord_gain) + 64'sd16384;
        acc = acc >>> 15;
        if (acc > 32767)
            acc = 32767;
        else if (acc < -32768)
            acc = -32768;
        return acc[15:0];
    endfunction

    // advance one copy of the player state by one command word
    task automatic play_command(input int cp, input word_t w,
                                output bit has_sample, output out_word_t s);
        int     hb;
        int     db;
        int     cnt;
        int     pos;
        bit     empty;
        point_t pt;
        hb = disp_bank[cp] ? 0 : 1;
        has_sample = 1'b0;
        s = '0;
        case (w.cmd)
            CMD_WRITE:
            begin
                pt.x = w.x;
                pt.y = w.y;
                pt.z = w.z;
                pt.blank = w.blank;
                pt.last = w.last;
                pt_mem[cp][hb * PPB + w.slot] = pt;
                if (cp == AHEAD)
                    slot_written[hb * PPB + w.slot] = 1'b1;
            end
            CMD_COMMIT:
            begin
                // counts above the bank size saturate
                bank_len[cp][hb] = (w.frame_len > PPB) ? PPB : int'(w.frame_len);
                swap_pending[cp] = 1'b1;
            end
            CMD_TICK:
            begin
                db = disp_bank[cp] ? 1 : 0;
                cnt = bank_len[cp][db];
                pos = play_pos[cp];
                // empty bank plays a blanked origin
                empty = (cnt == 0) || (pos >= cnt);
                if (empty)
                begin
                    pt = '0;
                    pt.blank = 1'b1;
                end
                else
                    pt = pt_mem[cp][db * PPB + pos];
                s.x = scale_coord(pt.x);
                s.y = scale_coord(pt.y);
                s.z = scale_coord(pt.z);
                s.laser_on = !pt.blank;
                // 8 bit hold counter, divider 0 means 256 ticks
                hold_cnt[cp] = hold_cnt[cp] + 8'd1;
                if (hold_cnt[cp] == tick_div)
                begin
                    hold_cnt[cp] = 8'd0;
                    if (empty || pt.last)
                        pos = 0;
                    else
                    begin
                        pos++;
                        if (pos >= cnt)
                            pos = 0;
                    end
                end
                play_pos[cp] = pos;
                // pending frame goes live only at the frame start
                if (pos == 0 && swap_pending[cp])
                begin
                    disp_bank[cp] = !disp_bank[cp];
                    swap_pending[cp] = 1'b0;
                    s.swapped = 1'b1;
                end
                has_sample = 1'b1;
            end
            default: ;
        endcase
    endtask

    // longest count that a bank can be played with without touching a slot
    // that was never written; a last flag inside the written prefix makes
    // any count safe
    function automatic int safe_len(input int bank);
        for (int i = 0; i < PPB; i++)
        begin
            if (!slot_written[bank * PPB + i])
                return i;
            if (pt_mem[AHEAD][bank * PPB + i].last)
                return PPB;
        end
        return PPB;
    endfunction

    // hand a word to the driver, after steering it away from unwritten reads
    task automatic queue_command(input word_t w);
        bit        has_sample;
        out_word_t s;
        int        hb;
        int        len;
        hb = disp_bank[AHEAD] ? 0 : 1;
        if (w.cmd == CMD_COMMIT)
        begin
            len = (w.frame_len > PPB) ? PPB : int'(w.frame_len);
            if (len > safe_len(hb))
                w.frame_len = 13'(safe_len(hb));
        end
        play_command(AHEAD, w, has_sample, s);
        // a write that drops a last flag may open a path into unwritten slots
        if (w.cmd == CMD_WRITE && bank_len[AHEAD][hb] > safe_len(hb))
        begin
            w.last = 1'b1;
            play_command(AHEAD, w, has_sample, s);
        end
        command_fifo.push_back(w);
        words_queued++;
        if (w.cmd != CMD_UNUSED)
            words_this_phase++;
    endtask

    function automatic word_t command_word(input logic [1:0] c, input logic [11:0] slot,
                                           input logic signed [15:0] x,
                                           input logic signed [15:0] y,
                                           input logic signed [15:0] z,
                                           input logic blank, input logic last,
                                           input logic [12:0] len);
        word_t w;
        w.cmd = c;
        w.slot = slot;
        w.x = x;
        w.y = y;
        w.z = z;
        w.blank = blank;
        w.last = last;
        w.frame_len = len;
        return w;
    endfunction

    // coordinates lean toward the extremes and the rounding corners
    function automatic logic signed [15:0] pick_coord();
        case ($urandom_range(0, 7))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return 16'sh0000;
            3: return 16'shffff;
            4: return 16'(int'($urandom_range(0, 6)) - 3);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic word_t random_point(input logic [11:0] slot, input logic last);
        return command_word(CMD_WRITE, slot, pick_coord(), pick_coord(), pick_coord(),
                            1'($urandom_range(0, 1)), last, '0);
    endfunction

    function automatic word_t tick_word();
        return command_word(CMD_TICK, '0, '0, '0, '0, 1'b0, 1'b0, '0);
    endfunction

    // well-formed frame: points from slot 0 up, a commit, then a run of ticks;
    // now and then a tick slips in between the writes
    task automatic load_and_play_frame();
        int          n;
        int          ticks;
        logic [12:0] len;
        logic        last;
        case ($urandom_range(0, 9))
            0: n = 1;
            9: n = $urandom_range(13, 48);
            default: n = $urandom_range(2, 12);
        endcase
        for (int i = 0; i < n; i++)
        begin
            if (i == n - 1)
                last = 1'($urandom_range(0, 1));
            else
                last = ($urandom_range(0, 15) == 0);
            queue_command(random_point(12'(i), last));
            if ($urandom_range(0, 7) == 0)
                queue_command(tick_word());
        end
        case ($urandom_range(0, 9))
            7: len = '0;
            8: len = 13'($urandom_range(0, 8191));
            9: len = 13'($urandom_range(4096, 8191));
            default: len = 13'(n);
        endcase
        queue_command(command_word(CMD_COMMIT, '0, '0, '0, '0, 1'b0, 1'b0, len));
        ticks = $urandom_range(1, 40);
        repeat (ticks)
            queue_command(tick_word());
    endtask

    // noise: stray writes anywhere, stray commits, lone ticks, unused code
    task automatic queue_stray_command();
        case ($urandom_range(0, 4))
            0: queue_command(random_point(12'($urandom_range(0, 4095)), 1'($urandom_range(0, 1))));
            1: queue_command(random_point(12'($urandom_range(0, 15)), 1'($urandom_range(0, 1))));
            2: queue_command(command_word(CMD_COMMIT, 12'($urandom), pick_coord(), '0, '0,
                                          1'b0, 1'b0, 13'($urandom_range(0, 8191))));
            3: queue_command(tick_word());
            default: queue_command(command_word(CMD_UNUSED, 12'($urandom), pick_coord(),
                                                pick_coord(), pick_coord(),
                                                1'($urandom_range(0, 1)),
                                                1'($urandom_range(0, 1)),
                                                13'($urandom_range(0, 8191))));
        endcase
    endtask

    // one register write on the configuration channel
    task automatic write_reg(input logic [7:0] idx, input logic [15:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_TICK_DIVIDER)
            tick_div = val[7:0];
        else if (idx == CFG_OUTPUT_GAIN)
            coord_gain = val;
    endtask

    // all words taken, all samples seen, then let writes and commits settle
    task automatic wait_until_idle();
        while (words_accepted != words_queued || sample_fifo.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    // stimulus: directed opening, then random phases under several settings
    initial
    begin : stimulus
        bit [7:0]  dv;
        bit [15:0] gn;

        // empty display bank at reset, then the unused command
        queue_command(tick_word());
        queue_command(command_word(CMD_UNUSED, 12'hfff, 16'sh7fff, 16'sh8000, 16'shffff,
                                   1'b1, 1'b1, 13'h1fff));
        // three point frame with coordinate extremes, plus the top slot
        queue_command(command_word(CMD_WRITE, 12'd0, 16'sh7fff, 16'sh8000, 16'sh0000,
                                   1'b0, 1'b0, '0));
        queue_command(command_word(CMD_WRITE, 12'd1, 16'shffff, 16'sh0001, 16'sh8000,
                                   1'b1, 1'b0, '0));
        queue_command(command_word(CMD_WRITE, 12'd2, 16'sd12345, -16'sd12345, 16'sh7fff,
                                   1'b0, 1'b1, '0));
        queue_command(command_word(CMD_WRITE, 12'hfff, 16'sh5555, 16'shaaaa, 16'sh5555,
                                   1'b1, 1'b0, '0));
        queue_command(command_word(CMD_COMMIT, '0, '0, '0, '0, 1'b0, 1'b0, 13'd3));
        // first tick swaps the frame in, the rest play it and wrap on last
        repeat (5)
            queue_command(tick_word());
        // oversized count saturates, then a repeated commit empties it again
        queue_command(command_word(CMD_WRITE, 12'd0, 16'sh8000, 16'sh7fff, 16'sh0001,
                                   1'b0, 1'b1, '0));
        queue_command(command_word(CMD_COMMIT, '0, '0, '0, '0, 1'b0, 1'b0, 13'h1fff));
        queue_command(command_word(CMD_COMMIT, '0, '0, '0, '0, 1'b0, 1'b0, 13'd0));
        repeat (3)
            queue_command(tick_word());
        queue_command(command_word(CMD_COMMIT, '0, '0, '0, '0, 1'b0, 1'b0, 13'd1));
        repeat (3)
            queue_command(tick_word());

        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;
        wait_until_idle();

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            dv = div_set[ph];
            gn = gain_set[ph];
            if (ph == NUM_PHASES - 1)
            begin
                dv = 8'($urandom_range(1, 6));
                gn = 16'($urandom_range(0, 65535));
            end
            write_reg(CFG_TICK_DIVIDER, {8'd0, dv});
            write_reg(CFG_OUTPUT_GAIN, gn);
            @(negedge clk);
            words_this_phase = 0;
            while (words_this_phase < WORDS_PER_PHASE)
            begin
                if ($urandom_range(0, 9) < 7)
                    load_and_play_frame();
                else
                    queue_stray_command();
            end
            wait_until_idle();
        end

        if (mismatches == 0 && sample_fifo.size() == 0)
            $display("laser_point_frame_player_unit test passed");
        else
            $display("laser_point_frame_player_unit test failed");
        $finish;
    end

    // driver: takes words from the queue in bursts with gaps between them;
    // the word on the bus only changes once the block has taken it
    always @(posedge clk or negedge rst_n)
    begin : drive_words
        bit        has_sample;
        out_word_t s;
        bit        send;
        if (!rst_n)
        begin
            in_valid    <= 1'b0;
            cmd         <= CMD_WRITE;
            point_index <= '0;
            in_x        <= '0;
            in_y        <= '0;
            in_z        <= '0;
            in_blank    <= 1'b0;
            in_last     <= 1'b0;
            frame_count <= '0;
            gap_left       = 0;
            burst_left     = 0;
            hold_for_drain = 1'b0;
        end
        else
        begin
            // word taken at this edge: predict its sample
            if (in_valid && !in_stall)
            begin
                play_command(LIVE, bus_word, has_sample, s);
                if (has_sample)
                    sample_fifo.push_back(s);
                words_accepted++;
            end
            if (!in_valid || !in_stall)
            begin
                send = 1'b0;
                if (hold_for_drain)
                begin
                    // hold off until every sample in flight has come out
                    if (sample_fifo.size() == 0)
                        hold_for_drain = 1'b0;
                end
                else if (gap_left > 0)
                    gap_left--;
                else if (command_fifo.size() > 0)
                begin
                    bus_word = command_fifo.pop_front();
                    send = 1'b1;
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        // end of a burst: pick the next gap and burst length
                        burst_left = $urandom_range(0, 23);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                        if ($urandom_range(0, 15) == 0)
                            gap_left = $urandom_range(10, 30);
                        hold_for_drain = ($urandom_range(0, 39) == 0);
                    end
                end
                in_valid <= send;
                if (send)
                begin
                    cmd         <= bus_word.cmd;
                    point_index <= bus_word.slot;
                    in_x        <= bus_word.x;
                    in_y        <= bus_word.y;
                    in_z        <= bus_word.z;
                    in_blank    <= bus_word.blank;
                    in_last     <= bus_word.last;
                    frame_count <= bus_word.frame_len;
                end
            end
        end
    end

    // monitor: checks each sample word against the oldest prediction and
    // drives the receiver stall pattern
    always @(posedge clk or negedge rst_n)
    begin : check_samples
        out_word_t want;
        bit        bad;
        bit        stall_next;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_mode = 0;
            mode_left  = 0;
            stall_cyc  = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (sample_fifo.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("unexpected sample word x=%0d y=%0d z=%0d on=%0b swap=%0b",
                                 x_out, y_out, z_out, laser_on, frame_swapped);
                    mismatches++;
                end
                else
                begin
                    want = sample_fifo.pop_front();
                    bad = (x_out !== want.x) || (y_out !== want.y) || (z_out !== want.z) ||
                          (laser_on !== want.laser_on) || (frame_swapped !== want.swapped);
                    if (bad)
                    begin
                        if (mismatches < 10)
                            $display({"sample mismatch: expected x=%0d y=%0d z=%0d on=%0b ",
                                      "swap=%0b, got x=%0d y=%0d z=%0d on=%0b swap=%0b"},
                                     want.x, want.y, want.z, want.laser_on, want.swapped,
                                     x_out, y_out, z_out, laser_on, frame_swapped);
                        mismatches++;
                    end
                end
            end
            // stall pattern: free running, random, evenly spaced single stalls, or blocks
            if (mode_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                mode_left  = $urandom_range(20, 150);
            end
            else
                mode_left--;
            stall_cyc++;
            case (stall_mode)
                1: stall_next = ($urandom_range(0, 3) == 0);
                2: stall_next = (stall_cyc % 3 == 0);
                3: stall_next = (stall_cyc % 16 < 6);
                default: stall_next = 1'b0;
            endcase
            out_stall <= stall_next;
        end
    end

    // watchdog: too long with no word moving on any channel ends the run
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
            (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles == WATCHDOG_LIMIT)
        begin
            $display("laser_point_frame_player_unit test failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

endmodule
